// ----- hdl/cbse_pkg.sv -----
// Shared types and constants for the cubic Bezier spline evaluator.
`timescale 1ns / 1ps
package cbse_pkg;
	localparam int CNT_W = 5;
	localparam logic [16:0] U_ONE = 17'h10000;

	localparam logic [CNT_W-1:0] READ_LAST = CNT_W'(3);
	localparam logic [CNT_W-1:0] WGT_LAST  = CNT_W'(7);
	localparam logic [CNT_W-1:0] ACC_LAST  = CNT_W'(12);
	localparam logic [CNT_W-1:0] SQ_LAST   = CNT_W'(3);
	localparam logic [CNT_W-1:0] SQRT_LAST = CNT_W'(31);
	localparam logic [CNT_W-1:0] DIV_LAST  = CNT_W'(16);

	typedef enum logic [1:0] {OP_CLEAR, OP_APPEND, OP_POINT, OP_DIR} op_t;
	typedef enum logic [1:0] {ST_OK, ST_BADCNT, ST_FULL, ST_ZERO} status_t;

	typedef enum logic [3:0] {
		S_IDLE, S_DECODE, S_SEGSET, S_READ, S_WGT, S_ACC, S_FINPT, S_ABS,
		S_NORM, S_SQ, S_SQRT_INIT, S_SQRT, S_DIV_INIT, S_DIV, S_DIV_FIN, S_DONE
	} state_t;

	typedef enum logic [4:0] {
		DP_NONE, DP_CAPTURE, DP_WRITE, DP_SEG, DP_SEGSET, DP_READ, DP_WGT, DP_ACC,
		DP_FINPT, DP_ABS, DP_NORM, DP_SQ, DP_SQRT_INIT, DP_SQRT, DP_DIV_INIT,
		DP_DIV, DP_DIV_FIN, DP_OUT
	} dp_op_t;

	typedef struct packed {
		dp_op_t            op;
		logic [CNT_W-1:0]  cnt;
		logic [1:0]        comp;
		status_t           st;
	} dp_cmd_t;

	typedef struct packed {
		op_t  op;
		logic full;
		logic count_ok;
		logic zero_tan;
		logic norm_done;
	} dp_stat_t;
endpackage

// ----- hdl/cbse_if.sv -----
// Valid/ready channel interfaces for the spline evaluator.
`timescale 1ns / 1ps
interface cbse_in_if;
	logic               valid;
	logic               ready;
	logic [1:0]         op;
	logic signed [31:0] coord_x;
	logic signed [31:0] coord_y;
	logic signed [31:0] coord_z;
	logic signed [17:0] param_t;
	modport source (output valid, op, coord_x, coord_y, coord_z, param_t, input ready);
	modport sink (input valid, op, coord_x, coord_y, coord_z, param_t, output ready);
endinterface

interface cbse_out_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] out_x;
	logic signed [31:0] out_y;
	logic signed [31:0] out_z;
	logic [1:0]         status;
	modport source (output valid, out_x, out_y, out_z, status, input ready);
	modport sink (input valid, out_x, out_y, out_z, status, output ready);
endinterface

// ----- hdl/cubic_bezier_spline_eval_top.sv -----
// Top level of the piecewise cubic Bezier spline evaluator.
`timescale 1ns / 1ps
// Holds up to MAX_POINTS control points (signed Q16.16) and evaluates a spline of
// k chained cubic segments (3k+1 points). Op 0 clears the store and writes the first
// point, op 1 appends one, op 2 returns the curve point at param_t (Q1.16, clamped to
// 0..1) and op 3 the unit tangent, each with a status code. One item is worked on at
// a time; a new one is taken while the previous result still waits in the output
// register. The work is done by the single shared multiplier (one product per cycle),
// the one-row-per-cycle read of the point store, the one-bit-per-cycle normalising
// shift, the 32-step square root and the 17-step divider used once for each axis.
module cubic_bezier_spline_eval_top #(
	parameter int MAX_POINTS = 64
) (
	input logic        clk,
	input logic        arst_n,
	cbse_in_if.sink    in_ch,
	cbse_out_if.source out_ch
);
	cbse_pkg::dp_cmd_t  dp_cmd;
	cbse_pkg::dp_stat_t dp_stat;

	cbse_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_ready  (in_ch.ready),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.cmd       (dp_cmd),
		.stat      (dp_stat)
	);

	cbse_datapath #(
		.MAX_POINTS (MAX_POINTS)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (dp_cmd),
		.stat       (dp_stat),
		.in_op      (in_ch.op),
		.in_x       (in_ch.coord_x),
		.in_y       (in_ch.coord_y),
		.in_z       (in_ch.coord_z),
		.in_t       (in_ch.param_t),
		.out_x      (out_ch.out_x),
		.out_y      (out_ch.out_y),
		.out_z      (out_ch.out_z),
		.out_status (out_ch.status)
	);

	// a beat in starts work, so the input side is busy in the next cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_ch.valid && in_ch.ready |=> !in_ch.ready)
		else $error("input ready while an item is in work");

	// the output register is only loaded when it is free or being drained
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(dp_cmd.op == cbse_pkg::DP_OUT) |-> (!out_ch.valid || out_ch.ready))
		else $error("pending result overwritten");

	// any error status comes with an all-zero vector
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && (out_ch.status != cbse_pkg::ST_OK) |->
		(out_ch.out_x == 32'sd0) && (out_ch.out_y == 32'sd0) && (out_ch.out_z == 32'sd0))
		else $error("non-zero result with error status");
endmodule

// ----- hdl/cbse_ctrl.sv -----
// Sequencer for the spline evaluator: steps the datapath through each operation.
`timescale 1ns / 1ps
module cbse_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  logic               out_ready,
	output cbse_pkg::dp_cmd_t  cmd,
	input  cbse_pkg::dp_stat_t stat
);
	cbse_pkg::state_t              state_q, state_d;
	logic [cbse_pkg::CNT_W-1:0]    cnt_q, cnt_d;
	logic [1:0]                    comp_q, comp_d;
	cbse_pkg::status_t             st_q, st_d;
	logic                          out_valid_q;
	logic                          load_out;

	// state and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= cbse_pkg::S_IDLE;
			cnt_q       <= '0;
			comp_q      <= '0;
			st_q        <= cbse_pkg::ST_OK;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			comp_q  <= comp_d;
			st_q    <= st_d;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

	// next state and datapath commands
	always_comb begin
		state_d  = state_q;
		cnt_d    = cnt_q;
		comp_d   = comp_q;
		st_d     = st_q;
		in_ready = 1'b0;
		load_out = 1'b0;
		cmd.op   = cbse_pkg::DP_NONE;
		cmd.cnt  = cnt_q;
		cmd.comp = comp_q;
		cmd.st   = st_q;
		unique case (state_q)
			cbse_pkg::S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.op  = cbse_pkg::DP_CAPTURE;
					state_d = cbse_pkg::S_DECODE;
				end
			end
			cbse_pkg::S_DECODE: begin
				if (stat.op == cbse_pkg::OP_CLEAR || stat.op == cbse_pkg::OP_APPEND) begin
					cmd.op  = cbse_pkg::DP_WRITE;
					st_d    = (stat.op == cbse_pkg::OP_APPEND && stat.full) ?
					          cbse_pkg::ST_FULL : cbse_pkg::ST_OK;
					state_d = cbse_pkg::S_DONE;
				end else if (!stat.count_ok) begin
					st_d    = cbse_pkg::ST_BADCNT;
					state_d = cbse_pkg::S_DONE;
				end else begin
					cmd.op  = cbse_pkg::DP_SEG;
					st_d    = cbse_pkg::ST_OK;
					state_d = cbse_pkg::S_SEGSET;
				end
			end
			cbse_pkg::S_SEGSET: begin
				cmd.op  = cbse_pkg::DP_SEGSET;
				cnt_d   = '0;
				state_d = cbse_pkg::S_READ;
			end
			cbse_pkg::S_READ: begin
				cmd.op = cbse_pkg::DP_READ;
				if (cnt_q == cbse_pkg::READ_LAST) begin
					cnt_d   = '0;
					state_d = cbse_pkg::S_WGT;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			cbse_pkg::S_WGT: begin
				cmd.op = cbse_pkg::DP_WGT;
				if (cnt_q == cbse_pkg::WGT_LAST) begin
					cnt_d   = '0;
					state_d = cbse_pkg::S_ACC;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			cbse_pkg::S_ACC: begin
				cmd.op = cbse_pkg::DP_ACC;
				if (cnt_q == cbse_pkg::ACC_LAST) begin
					cnt_d   = '0;
					state_d = (stat.op == cbse_pkg::OP_POINT) ?
					          cbse_pkg::S_FINPT : cbse_pkg::S_ABS;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			cbse_pkg::S_FINPT: begin
				cmd.op  = cbse_pkg::DP_FINPT;
				state_d = cbse_pkg::S_DONE;
			end
			cbse_pkg::S_ABS: begin
				cmd.op  = cbse_pkg::DP_ABS;
				state_d = cbse_pkg::S_NORM;
			end
			cbse_pkg::S_NORM: begin
				if (stat.zero_tan) begin
					st_d    = cbse_pkg::ST_ZERO;
					state_d = cbse_pkg::S_DONE;
				end else if (stat.norm_done) begin
					cnt_d   = '0;
					state_d = cbse_pkg::S_SQ;
				end else begin
					cmd.op = cbse_pkg::DP_NORM;
				end
			end
			cbse_pkg::S_SQ: begin
				cmd.op = cbse_pkg::DP_SQ;
				if (cnt_q == cbse_pkg::SQ_LAST) begin
					cnt_d   = '0;
					state_d = cbse_pkg::S_SQRT_INIT;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			cbse_pkg::S_SQRT_INIT: begin
				cmd.op  = cbse_pkg::DP_SQRT_INIT;
				cnt_d   = '0;
				state_d = cbse_pkg::S_SQRT;
			end
			cbse_pkg::S_SQRT: begin
				cmd.op = cbse_pkg::DP_SQRT;
				if (cnt_q == cbse_pkg::SQRT_LAST) begin
					cnt_d   = '0;
					comp_d  = '0;
					state_d = cbse_pkg::S_DIV_INIT;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			cbse_pkg::S_DIV_INIT: begin
				cmd.op  = cbse_pkg::DP_DIV_INIT;
				cnt_d   = '0;
				state_d = cbse_pkg::S_DIV;
			end
			cbse_pkg::S_DIV: begin
				cmd.op = cbse_pkg::DP_DIV;
				if (cnt_q == cbse_pkg::DIV_LAST) begin
					cnt_d   = '0;
					state_d = cbse_pkg::S_DIV_FIN;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			cbse_pkg::S_DIV_FIN: begin
				cmd.op = cbse_pkg::DP_DIV_FIN;
				if (comp_q == 2'd2) begin
					state_d = cbse_pkg::S_DONE;
				end else begin
					comp_d  = comp_q + 1'b1;
					state_d = cbse_pkg::S_DIV_INIT;
				end
			end
			cbse_pkg::S_DONE: begin
				// wait for the output register to be free
				if (!out_valid_q || out_ready) begin
					cmd.op   = cbse_pkg::DP_OUT;
					load_out = 1'b1;
					state_d  = cbse_pkg::S_IDLE;
				end
			end
			default: state_d = cbse_pkg::S_IDLE;
		endcase
	end
endmodule

// ----- hdl/cbse_datapath.sv -----
// Point store, shared multiplier, square root and divider of the spline evaluator.
`timescale 1ns / 1ps
module cbse_datapath #(
	parameter int MAX_POINTS = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  cbse_pkg::dp_cmd_t  cmd,
	output cbse_pkg::dp_stat_t stat,
	input  logic [1:0]         in_op,
	input  logic signed [31:0] in_x,
	input  logic signed [31:0] in_y,
	input  logic signed [31:0] in_z,
	input  logic signed [17:0] in_t,
	output logic signed [31:0] out_x,
	output logic signed [31:0] out_y,
	output logic signed [31:0] out_z,
	output logic [1:0]         out_status
);
	localparam int AW   = $clog2(MAX_POINTS);
	localparam int CW   = $clog2(MAX_POINTS + 1);
	localparam int KMAX = (MAX_POINTS - 1) / 3;
	localparam int KW   = $clog2(KMAX + 1);
	localparam logic [50:0] RND18 = 51'(1) << 17;
	localparam int CNT_W_M1 = cbse_pkg::CNT_W - 1;

	function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
		logic signed [31:0] r;
		if (v[33:31] == 3'b000 || v[33:31] == 3'b111) begin
			r = v[31:0];
		end else if (v[33]) begin
			r = 32'sh8000_0000;
		end else begin
			r = 32'sh7fff_ffff;
		end
		return r;
	endfunction

	// captured item and store bookkeeping
	cbse_pkg::op_t      op_q;
	logic signed [31:0] cx_q, cy_q, cz_q;
	logic signed [17:0] t_q;
	logic [CW-1:0]      count_q;
	logic [1:0]         phase_q;
	logic [KW-1:0]      k_q;

	logic [31:0] mem_x [MAX_POINTS];
	logic [31:0] mem_y [MAX_POINTS];
	logic [31:0] mem_z [MAX_POINTS];

	logic [AW-1:0]      base_q;
	logic [16:0]        u_q, d_q;
	logic signed [31:0] p_q [4][3];
	logic signed [63:0] prod_q;
	logic [32:0]        dd_q, uu_q, du_q;
	logic [30:0]        w_q [4];
	logic signed [63:0] s_q [3];
	logic [63:0]        m_q [3];
	logic               neg_q [3];
	logic [63:0]        sum_q, sv_q, sr_q, sb_q;
	logic [47:0]        rem_q, den_q;
	logic [16:0]        q_q;
	logic signed [31:0] res_q [3];

	logic               full, wr_en, ge1;
	logic [AW-1:0]      wr_addr, rd_addr;
	logic [15:0]        t_lo;
	logic [KW-1:0]      seg;
	logic [16:0]        u_n;
	logic [28:0]        tw [4];
	logic signed [32:0] diff [4][3];
	logic [32:0]        dd_r, uu_r;
	logic [32:0]        du_r;
	logic [1:0]         a_term, a_comp, b_term, b_comp;
	logic [CNT_W_M1:0]  pc;
	logic signed [33:0] ma, mb;
	logic signed [67:0] mp;
	logic [50:0]        rnd_a, rnd_b;
	logic               hi, lo;
	logic [63:0]        sq_t;
	logic [31:0]        len;

	assign full    = (count_q == CW'(MAX_POINTS));
	assign wr_en   = (cmd.op == cbse_pkg::DP_WRITE) && (op_q == cbse_pkg::OP_CLEAR || !full);
	assign wr_addr = (op_q == cbse_pkg::OP_CLEAR) ? '0 : count_q[AW-1:0];
	assign rd_addr = base_q + AW'(cmd.cnt[1:0]);

	// parameter clamp and segment select
	assign t_lo = t_q[17] ? 16'h0 : t_q[15:0];
	assign ge1  = !t_q[17] && t_q[16];
	assign seg  = ge1 ? (k_q - 1'b1) : prod_q[16 +: KW];
	assign u_n  = ge1 ? cbse_pkg::U_ONE : {1'b0, prod_q[15:0]};

	// derivative weights rounded to Q.28, and control point differences
	assign dd_r  = dd_q + 33'd8;
	assign uu_r  = uu_q + 33'd8;
	assign du_r  = du_q + 33'd4;
	assign tw[0] = dd_r[32:4];
	assign tw[1] = du_r[31:3];
	assign tw[2] = uu_r[32:4];
	assign tw[3] = '0;
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			for (int c = 0; c < 3; c++) begin
				diff[i][c] = 33'(p_q[i+1][c]) - 33'(p_q[i][c]);
			end
		end
		for (int c = 0; c < 3; c++) begin
			diff[3][c] = '0;
		end
	end

	// issue and write-back slots of the accumulation sequence
	assign a_term = cmd.cnt[1:0];
	assign a_comp = cmd.cnt[3:2];
	assign pc     = cmd.cnt - 1'b1;
	assign b_term = pc[1:0];
	assign b_comp = pc[3:2];

	// shared multiplier operand select
	always_comb begin
		ma = '0;
		mb = '0;
		unique case (cmd.op)
			cbse_pkg::DP_SEG: begin
				ma = 34'(t_lo);
				mb = 34'(k_q);
			end
			cbse_pkg::DP_WGT: begin
				unique case (cmd.cnt[2:0])
					3'd0: begin ma = 34'(d_q);  mb = 34'(d_q); end
					3'd1: begin ma = 34'(u_q);  mb = 34'(u_q); end
					3'd2: begin ma = 34'(d_q);  mb = 34'(u_q); end
					3'd3: begin ma = 34'(dd_q); mb = 34'(d_q); end
					3'd4: begin ma = 34'(dd_q); mb = 34'(u_q); end
					3'd5: begin ma = 34'(uu_q); mb = 34'(d_q); end
					3'd6: begin ma = 34'(uu_q); mb = 34'(u_q); end
					default: begin ma = '0; mb = '0; end
				endcase
			end
			cbse_pkg::DP_ACC: begin
				if (a_comp != 2'd3) begin
					if (op_q == cbse_pkg::OP_POINT) begin
						ma = 34'(w_q[a_term]);
						mb = 34'(p_q[a_term][a_comp]);
					end else begin
						ma = 34'(tw[a_term]);
						mb = 34'(diff[a_term][a_comp]);
					end
				end
			end
			cbse_pkg::DP_SQ: begin
				if (cmd.cnt[1:0] != 2'd3) begin
					ma = 34'(m_q[cmd.cnt[1:0]][29:0]);
					mb = 34'(m_q[cmd.cnt[1:0]][29:0]);
				end
			end
			default: begin
				ma = '0;
				mb = '0;
			end
		endcase
	end
	assign mp = ma * mb;

	// Bernstein weight rounding, plain and times three
	assign rnd_a = 51'(prod_q[48:0]) + RND18;
	assign rnd_b = 51'(prod_q[48:0]) + 51'({prod_q[48:0], 1'b0}) + RND18;

	// normalisation window and square root trial
	always_comb begin
		hi = 1'b0;
		lo = 1'b1;
		for (int c = 0; c < 3; c++) begin
			hi = hi | (|m_q[c][63:30]);
			lo = lo & ~(|m_q[c][63:29]);
		end
	end
	assign sq_t = sr_q + sb_q;
	assign len  = sr_q[31:0];

	assign stat.op        = op_q;
	assign stat.full      = full;
	assign stat.count_ok  = (count_q >= CW'(4)) && (phase_q == 2'd0);
	assign stat.zero_tan  = (m_q[0] == '0) && (m_q[1] == '0) && (m_q[2] == '0);
	assign stat.norm_done = !hi && !lo;

	// store bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			phase_q <= '0;
			k_q     <= '0;
		end else if (cmd.op == cbse_pkg::DP_WRITE) begin
			if (op_q == cbse_pkg::OP_CLEAR) begin
				count_q <= CW'(1);
				phase_q <= '0;
				k_q     <= '0;
			end else if (!full) begin
				count_q <= count_q + 1'b1;
				if (phase_q == 2'd2) begin
					phase_q <= '0;
					k_q     <= k_q + 1'b1;
				end else begin
					phase_q <= phase_q + 1'b1;
				end
			end
		end
	end

	// point store
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_x[wr_addr] <= cx_q;
			mem_y[wr_addr] <= cy_q;
			mem_z[wr_addr] <= cz_q;
		end
		if (cmd.op == cbse_pkg::DP_READ) begin
			p_q[cmd.cnt[1:0]][0] <= mem_x[rd_addr];
			p_q[cmd.cnt[1:0]][1] <= mem_y[rd_addr];
			p_q[cmd.cnt[1:0]][2] <= mem_z[rd_addr];
		end
	end

	// arithmetic registers
	always_ff @(posedge clk) begin
		prod_q <= mp[63:0];
		unique case (cmd.op)
			cbse_pkg::DP_CAPTURE: begin
				op_q <= cbse_pkg::op_t'(in_op);
				cx_q <= in_x;
				cy_q <= in_y;
				cz_q <= in_z;
				t_q  <= in_t;
				for (int c = 0; c < 3; c++) begin
					res_q[c] <= '0;
				end
			end
			cbse_pkg::DP_SEGSET: begin
				base_q <= AW'({seg, 1'b0}) + AW'(seg);
				u_q    <= u_n;
				d_q    <= cbse_pkg::U_ONE - u_n;
			end
			cbse_pkg::DP_WGT: begin
				unique case (cmd.cnt[2:0])
					3'd1: dd_q <= prod_q[32:0];
					3'd2: uu_q <= prod_q[32:0];
					3'd3: du_q <= prod_q[32:0];
					3'd4: w_q[0] <= rnd_a[48:18];
					3'd5: w_q[1] <= rnd_b[48:18];
					3'd6: w_q[2] <= rnd_b[48:18];
					3'd7: w_q[3] <= rnd_a[48:18];
					default: ;
				endcase
			end
			cbse_pkg::DP_ACC: begin
				if (cmd.cnt != '0 && b_comp != 2'd3) begin
					s_q[b_comp] <= (b_term == 2'd0) ? prod_q : (s_q[b_comp] + prod_q);
				end
			end
			cbse_pkg::DP_FINPT: begin
				for (int c = 0; c < 3; c++) begin
					res_q[c] <= sat32(34'((s_q[c] + 64'sd536870912) >>> 30));
				end
			end
			cbse_pkg::DP_ABS: begin
				for (int c = 0; c < 3; c++) begin
					neg_q[c] <= s_q[c][63];
					m_q[c]   <= s_q[c][63] ? 64'(-s_q[c]) : 64'(s_q[c]);
				end
			end
			cbse_pkg::DP_NORM: begin
				for (int c = 0; c < 3; c++) begin
					if (hi) begin
						m_q[c] <= m_q[c] >> 1;
					end else if (lo) begin
						m_q[c] <= m_q[c] << 1;
					end
				end
			end
			cbse_pkg::DP_SQ: begin
				if (cmd.cnt != '0) begin
					sum_q <= (cmd.cnt == cbse_pkg::CNT_W'(1)) ? 64'(prod_q) :
					         (sum_q + 64'(prod_q));
				end
			end
			cbse_pkg::DP_SQRT_INIT: begin
				sv_q <= sum_q;
				sr_q <= '0;
				sb_q <= 64'(1) << 62;
			end
			cbse_pkg::DP_SQRT: begin
				if (sv_q >= sq_t) begin
					sv_q <= sv_q - sq_t;
					sr_q <= (sr_q >> 1) + sb_q;
				end else begin
					sr_q <= sr_q >> 1;
				end
				sb_q <= sb_q >> 2;
			end
			cbse_pkg::DP_DIV_INIT: begin
				if (cmd.comp != 2'd3) begin
					rem_q <= {m_q[cmd.comp][31:0], 16'h0} + 48'(len[31:1]);
				end
				den_q <= {len, 16'h0};
				q_q   <= '0;
			end
			cbse_pkg::DP_DIV: begin
				if (rem_q >= den_q) begin
					rem_q <= rem_q - den_q;
					q_q   <= {q_q[15:0], 1'b1};
				end else begin
					q_q   <= {q_q[15:0], 1'b0};
				end
				den_q <= den_q >> 1;
			end
			cbse_pkg::DP_DIV_FIN: begin
				if (cmd.comp != 2'd3) begin
					res_q[cmd.comp] <= neg_q[cmd.comp] ? -32'(q_q) : 32'(q_q);
				end
			end
			cbse_pkg::DP_OUT: begin
				out_x      <= res_q[0];
				out_y      <= res_q[1];
				out_z      <= res_q[2];
				out_status <= cmd.st;
			end
			default: ;
		endcase
	end
endmodule

// ----- dv/tb_top.sv -----
// Self-checking testbench for the cubic Bezier spline evaluator.
`timescale 1ns / 1ps
module tb_top;
	localparam int STORE_DEPTH = 64;
	localparam int RAND_ITEMS  = 1900;
	localparam int QUIET_FROM  = 1700;
	localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;
	localparam logic signed [31:0] Q_MAX = 32'sh7fff_ffff;
	localparam logic signed [17:0] T_ONE = 18'sd65536;
	localparam logic signed [17:0] T_MIN = 18'sh2_0000;

	typedef struct {
		logic signed [31:0]  x, y, z;
		cbse_pkg::status_t   st;
	} spline_res_t;

	typedef struct {
		cbse_pkg::op_t      op;
		logic signed [31:0] x, y, z;
		logic signed [17:0] t;
		bit                 typed;
		spline_res_t        want;
	} spline_item_t;

	logic clk;
	logic arst_n;
	cbse_in_if  in_ch();
	cbse_out_if out_ch();

	cubic_bezier_spline_eval_top #(.MAX_POINTS(STORE_DEPTH)) uut (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch)
	);

	// shadow copy of the point store
	logic signed [31:0] shadow_pt [STORE_DEPTH][3];
	int unsigned        shadow_cnt;

	spline_res_t pending_res [$];
	int  n_err, n_sent, n_seen;
	int  n_pt, n_dir, n_bad, n_full, n_zero;
	bit  quiet;

	always begin
		clk = 1'b1; #2;
		clk = 1'b0; #2;
	end

	function automatic logic signed [31:0] clip32(longint v);
		if (v > longint'(Q_MAX)) return Q_MAX;
		if (v < longint'(Q_MIN)) return Q_MIN;
		return v[31:0];
	endfunction

	function automatic longint unsigned floor_sqrt(longint unsigned v);
		longint unsigned acc, bitv;
		acc = 0;
		bitv = 64'd1 << 62;
		while (bitv > v) bitv >>= 2;
		while (bitv != 0) begin
			if (v >= acc + bitv) begin
				v -= acc + bitv;
				acc = (acc >> 1) + bitv;
			end else begin
				acc >>= 1;
			end
			bitv >>= 2;
		end
		return acc;
	endfunction

	// point store update and curve / tangent evaluation for one beat
	function automatic spline_res_t spline_apply(spline_item_t it);
		spline_res_t r;
		longint t, s, diff, q;
		longint unsigned u, d, sc, mx, sum, len;
		longint unsigned w [4];
		longint unsigned m [3];
		bit neg [3];
		int unsigned k, b;
		r.x = 0; r.y = 0; r.z = 0; r.st = cbse_pkg::ST_OK;
		if (it.op == cbse_pkg::OP_CLEAR || it.op == cbse_pkg::OP_APPEND) begin
			if (it.op == cbse_pkg::OP_CLEAR) shadow_cnt = 0;
			if (shadow_cnt >= STORE_DEPTH) begin
				r.st = cbse_pkg::ST_FULL;
			end else begin
				shadow_pt[shadow_cnt][0] = it.x;
				shadow_pt[shadow_cnt][1] = it.y;
				shadow_pt[shadow_cnt][2] = it.z;
				shadow_cnt++;
			end
			return r;
		end
		if (shadow_cnt < 4 || (shadow_cnt - 1) % 3 != 0) begin
			r.st = cbse_pkg::ST_BADCNT;
			return r;
		end
		k = (shadow_cnt - 1) / 3;
		t = longint'(it.t);
		if (t < 0) t = 0;
		if (t >= 65536) begin
			b = (k - 1) * 3;
			u = 65536;
		end else begin
			sc = longint'(t) * k;
			b = 32'((sc >> 16) * 3);
			u = sc & 64'hffff;
		end
		d = 65536 - u;
		if (it.op == cbse_pkg::OP_POINT) begin
			w[0] = d * d * d;
			w[1] = 3 * d * d * u;
			w[2] = 3 * d * u * u;
			w[3] = u * u * u;
			for (int i = 0; i < 4; i++) w[i] = (w[i] + (64'd1 << 17)) >> 18;
			for (int c = 0; c < 3; c++) begin
				s = 0;
				for (int i = 0; i < 4; i++)
					s += longint'(w[i]) * longint'(shadow_pt[b+i][c]);
				q = (s + (longint'(1) << 29)) >>> 30;
				if (c == 0) r.x = clip32(q);
				else if (c == 1) r.y = clip32(q);
				else r.z = clip32(q);
			end
			return r;
		end
		// tangent: weights in Q.28, then normalise to unit length
		w[0] = (d * d + 8) >> 4;
		w[1] = (2 * d * u + 8) >> 4;
		w[2] = (u * u + 8) >> 4;
		mx = 0;
		for (int c = 0; c < 3; c++) begin
			s = 0;
			for (int i = 0; i < 3; i++) begin
				diff = longint'(shadow_pt[b+i+1][c]) - longint'(shadow_pt[b+i][c]);
				s += longint'(w[i]) * diff;
			end
			neg[c] = s < 0;
			m[c] = neg[c] ? longint'(-s) : longint'(s);
			if (m[c] > mx) mx = m[c];
		end
		if (mx == 0) begin
			r.st = cbse_pkg::ST_ZERO;
			return r;
		end
		while (mx >= (64'd1 << 30)) begin
			for (int c = 0; c < 3; c++) m[c] >>= 1;
			mx >>= 1;
		end
		while (mx < (64'd1 << 29)) begin
			for (int c = 0; c < 3; c++) m[c] <<= 1;
			mx <<= 1;
		end
		sum = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
		len = floor_sqrt(sum);
		for (int c = 0; c < 3; c++) begin
			q = longint'((m[c] * 65536 + len / 2) / len);
			if (neg[c]) q = -q;
			if (c == 0) r.x = clip32(q);
			else if (c == 1) r.y = clip32(q);
			else r.z = clip32(q);
		end
		return r;
	endfunction

	task automatic report_mismatch(string msg);
		$display("MISMATCH beat %0d: %s", n_seen, msg);
		n_err++;
	endtask

	// send one beat, with an optional idle burst ahead of it
	task automatic send_beat(spline_item_t it);
		spline_res_t r;
		int gap;
		gap = (!quiet && $urandom_range(0, 3) == 0) ? $urandom_range(1, 9) : 0;
		if (gap != 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid   <= 1'b1;
		in_ch.op      <= it.op;
		in_ch.coord_x <= it.x;
		in_ch.coord_y <= it.y;
		in_ch.coord_z <= it.z;
		in_ch.param_t <= it.t;
		do @(posedge clk); while (!in_ch.ready);
		r = spline_apply(it);
		if (it.typed) r = it.want;
		case (r.st)
			cbse_pkg::ST_BADCNT: n_bad++;
			cbse_pkg::ST_FULL:   n_full++;
			cbse_pkg::ST_ZERO:   n_zero++;
			default: begin
				if (it.op == cbse_pkg::OP_POINT) n_pt++;
				if (it.op == cbse_pkg::OP_DIR) n_dir++;
			end
		endcase
		pending_res = {pending_res, r};
		n_sent++;
	endtask

	function automatic spline_item_t mk(cbse_pkg::op_t op, logic signed [31:0] x,
			logic signed [31:0] y, logic signed [31:0] z, logic signed [17:0] t);
		spline_item_t it;
		it.op = op; it.x = x; it.y = y; it.z = z; it.t = t;
		it.typed = 1'b0;
		it.want.x = 0; it.want.y = 0; it.want.z = 0; it.want.st = cbse_pkg::ST_OK;
		return it;
	endfunction

	function automatic spline_item_t mk_typed(cbse_pkg::op_t op, logic signed [31:0] x,
			logic signed [31:0] y, logic signed [31:0] z, logic signed [17:0] t,
			cbse_pkg::status_t st);
		spline_item_t it;
		it = mk(op, x, y, z, t);
		it.typed = 1'b1;
		it.want.st = st;
		return it;
	endfunction

	function automatic logic signed [31:0] rand_coord();
		case ($urandom_range(0, 9))
			0, 1, 2, 3: return $urandom;
			4, 5, 6, 7: return $signed($urandom_range(0, 2097151)) - 1048576;
			8: return $urandom_range(0, 1) ? Q_MAX : Q_MIN;
			default: return $urandom_range(0, 1) ? 32'sd0 : -32'sd1;
		endcase
	endfunction

	function automatic logic signed [17:0] rand_param();
		case ($urandom_range(0, 9))
			0: return 18'sd0;
			1: return T_ONE;
			2, 3: return 18'($urandom);
			default: return 18'($urandom_range(0, 65536));
		endcase
	endfunction

	function automatic cbse_pkg::op_t rand_eval_op();
		return $urandom_range(0, 1) ? cbse_pkg::OP_DIR : cbse_pkg::OP_POINT;
	endfunction

	// output side: random stall bursts, compare against the oldest expectation
	int stall_left;
	always @(posedge clk or negedge arst_n) begin
		spline_res_t e;
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
			stall_left = 0;
		end else begin
			if (out_ch.valid && out_ch.ready) begin
				n_seen++;
				if (pending_res.size() == 0) begin
					report_mismatch("result with nothing expected");
				end else begin
					e = pending_res.pop_front();
					if (out_ch.out_x !== e.x)
						report_mismatch($sformatf("out_x got %0d, expected %0d",
							out_ch.out_x, e.x));
					if (out_ch.out_y !== e.y)
						report_mismatch($sformatf("out_y got %0d, expected %0d",
							out_ch.out_y, e.y));
					if (out_ch.out_z !== e.z)
						report_mismatch($sformatf("out_z got %0d, expected %0d",
							out_ch.out_z, e.z));
					if (out_ch.status !== e.st)
						report_mismatch($sformatf("status got %0d, expected %0d",
							out_ch.status, e.st));
				end
			end
			if (quiet) begin
				out_ch.ready <= 1'b1;
			end else if (stall_left > 0) begin
				stall_left--;
				out_ch.ready <= 1'b0;
			end else if ($urandom_range(0, 4) == 0) begin
				stall_left = $urandom_range(0, 8);
				out_ch.ready <= 1'b0;
			end else begin
				out_ch.ready <= 1'b1;
			end
		end
	end

	// watchdog
	initial begin
		#20ms;
		$display("timeout with %0d results outstanding", pending_res.size());
		$display("** cubic_bezier_spline_eval_top: FAILED **");
		$finish;
	end

	initial begin
		spline_item_t dir_rows [$];
		int k, n_ev, n_rnd;
		logic signed [31:0] px, py, pz;
		n_err = 0; n_sent = 0; n_seen = 0; quiet = 1'b0;
		n_pt = 0; n_dir = 0; n_bad = 0; n_full = 0; n_zero = 0;
		shadow_cnt = 0;
		arst_n = 1'b0;
		in_ch.valid = 1'b0; in_ch.op = cbse_pkg::OP_CLEAR;
		in_ch.coord_x = 0; in_ch.coord_y = 0; in_ch.coord_z = 0; in_ch.param_t = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed rows: empty store, extreme coordinates and parameters, degenerate curve
		dir_rows = {
			mk_typed(cbse_pkg::OP_POINT, 0, 0, 0, 0, cbse_pkg::ST_BADCNT),
			mk_typed(cbse_pkg::OP_DIR, 0, 0, 0, T_ONE, cbse_pkg::ST_BADCNT),
			mk_typed(cbse_pkg::OP_CLEAR, Q_MIN, Q_MAX, 0, 0, cbse_pkg::ST_OK),
			mk_typed(cbse_pkg::OP_APPEND, Q_MAX, Q_MIN, 1, 0, cbse_pkg::ST_OK),
			mk_typed(cbse_pkg::OP_POINT, 0, 0, 0, 18'sd100, cbse_pkg::ST_BADCNT),
			mk_typed(cbse_pkg::OP_APPEND, 0, 0, 0, 0, cbse_pkg::ST_OK),
			mk_typed(cbse_pkg::OP_APPEND, Q_MIN, Q_MAX, -1, 0, cbse_pkg::ST_OK),
			mk(cbse_pkg::OP_POINT, 0, 0, 0, 0),
			mk(cbse_pkg::OP_POINT, 0, 0, 0, T_ONE),
			mk(cbse_pkg::OP_POINT, 0, 0, 0, T_MIN),
			mk(cbse_pkg::OP_POINT, 0, 0, 0, 18'sd131071),
			mk(cbse_pkg::OP_POINT, 0, 0, 0, 18'sd32768),
			mk(cbse_pkg::OP_DIR, 0, 0, 0, 0),
			mk(cbse_pkg::OP_DIR, 0, 0, 0, T_ONE),
			mk(cbse_pkg::OP_DIR, 0, 0, 0, -18'sd5),
			mk(cbse_pkg::OP_DIR, 0, 0, 0, 18'sd40000),
			mk_typed(cbse_pkg::OP_CLEAR, 5, 5, 5, 0, cbse_pkg::ST_OK),
			mk_typed(cbse_pkg::OP_APPEND, 5, 5, 5, 0, cbse_pkg::ST_OK),
			mk_typed(cbse_pkg::OP_APPEND, 5, 5, 5, 0, cbse_pkg::ST_OK),
			mk_typed(cbse_pkg::OP_APPEND, 5, 5, 5, 0, cbse_pkg::ST_OK),
			mk_typed(cbse_pkg::OP_DIR, 0, 0, 0, 18'sd30000, cbse_pkg::ST_ZERO),
			mk(cbse_pkg::OP_POINT, 0, 0, 0, 18'sd40000),
			mk_typed(cbse_pkg::OP_APPEND, 7, 7, 7, 0, cbse_pkg::ST_OK),
			mk_typed(cbse_pkg::OP_POINT, 0, 0, 0, 0, cbse_pkg::ST_BADCNT)
		};
		foreach (dir_rows[i]) send_beat(dir_rows[i]);

		// random part: mostly well-formed splines, some full-store fills, some noise
		n_rnd = 0;
		while (n_rnd < RAND_ITEMS) begin
			if (n_rnd >= QUIET_FROM) quiet = 1'b1;
			k = $urandom_range(0, 99);
			if (k < 4) begin
				send_beat(mk(cbse_pkg::OP_CLEAR, rand_coord(), rand_coord(), rand_coord(),
					rand_param()));
				for (int i = 1; i < STORE_DEPTH + 3; i++)
					send_beat(mk(cbse_pkg::OP_APPEND, rand_coord(), rand_coord(),
						rand_coord(), rand_param()));
				for (int i = 0; i < 3; i++)
					send_beat(mk(rand_eval_op(), 0, 0, 0, rand_param()));
				n_rnd += STORE_DEPTH + 6;
			end else if (k < 80) begin
				k = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 21) : $urandom_range(1, 3);
				px = rand_coord(); py = rand_coord(); pz = rand_coord();
				send_beat(mk(cbse_pkg::OP_CLEAR, px, py, pz, rand_param()));
				for (int i = 0; i < 3 * k; i++) begin
					// repeated points give flat stretches and zero tangents
					if ($urandom_range(0, 5) != 0) begin
						px = rand_coord(); py = rand_coord(); pz = rand_coord();
					end
					send_beat(mk(cbse_pkg::OP_APPEND, px, py, pz, rand_param()));
				end
				n_ev = $urandom_range(3, 8);
				for (int i = 0; i < n_ev; i++)
					send_beat(mk(rand_eval_op(), rand_coord(), rand_coord(), rand_coord(),
						rand_param()));
				n_rnd += 3 * k + 1 + n_ev;
			end else begin
				send_beat(mk(cbse_pkg::op_t'($urandom_range(0, 3)), rand_coord(),
					rand_coord(), rand_coord(), rand_param()));
				n_rnd++;
			end
		end
		in_ch.valid <= 1'b0;

		while (pending_res.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		$display("%0d beats sent, %0d results checked: %0d points, %0d tangents,",
			n_sent, n_seen, n_pt, n_dir);
		$display("%0d bad-count, %0d store-full and %0d zero-tangent results, %0d mismatches",
			n_bad, n_full, n_zero, n_err);
		if (n_err == 0) begin
			$display("** cubic_bezier_spline_eval_top: PASSED **");
		end else begin
			$display("** cubic_bezier_spline_eval_top: FAILED **");
		end
		$finish;
	end
endmodule

// ----- cubic_bezier_spline_eval_top.f -----
hdl/cbse_pkg.sv
hdl/cbse_if.sv
hdl/cbse_ctrl.sv
hdl/cbse_datapath.sv
hdl/cubic_bezier_spline_eval_top.sv
dv/tb_top.sv
